FILE: rtl/core/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types and constants of the skinning unit
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int MAT_ELEMS = 12;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_INFL  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              kind;
        logic [7:0]         bone;
        logic [3:0]         element;
        logic signed [31:0] matrix_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic [15:0]        weight;
        logic               last;
        logic               load_ok;
        logic               infl_ok;
    } item_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ELEM_WAIT,
        B_ELEM_MUL,
        B_ELEM_ACC,
        B_WGT_MUL,
        B_WGT_ADD,
        B_FINISH,
        B_NORM_START,
        B_NORM_WAIT,
        B_OUT
    } back_state_t;

    typedef enum logic [3:0] {
        N_IDLE,
        N_MAX,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV_INIT,
        N_DIV_STEP,
        N_DIV_END,
        N_DONE
    } norm_state_t;

endpackage

FILE: rtl/core/lbs_front.sv
// ----------------------------------------------------------------------------
// lbs_front
// accepts requests and classifies them for the back end
// ----------------------------------------------------------------------------
module lbs_front #(
    parameter int BONE_COUNT = 256
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [207:0]         s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output lbs_pkg::item_t       q_item
);

    logic [15:0] w_raw;
    logic        bone_ok;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign w_raw    = s_tdata[203:188];
    assign bone_ok  = ({1'b0, s_tdata[7:0]} < 9'(BONE_COUNT));

    always_comb begin
        q_item.kind         = lbs_pkg::mode_t'(s_tuser);
        q_item.bone         = s_tdata[7:0];
        q_item.element      = s_tdata[11:8];
        q_item.matrix_value = s_tdata[43:12];
        q_item.pos_x        = s_tdata[75:44];
        q_item.pos_y        = s_tdata[107:76];
        q_item.pos_z        = s_tdata[139:108];
        q_item.nrm_x        = s_tdata[155:140];
        q_item.nrm_y        = s_tdata[171:156];
        q_item.nrm_z        = s_tdata[187:172];
        q_item.weight       = (w_raw > lbs_pkg::ONE_Q15) ? lbs_pkg::ONE_Q15 : w_raw;
        q_item.last         = s_tlast;
        q_item.load_ok      = bone_ok && (s_tdata[11:8] < 4'(lbs_pkg::MAT_ELEMS));
        q_item.infl_ok      = bone_ok && (w_raw != 16'd0);
    end

endmodule

FILE: rtl/core/lbs_queue.sv
// ----------------------------------------------------------------------------
// lbs_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module lbs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lbs_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lbs_pkg::item_t head
);

    lbs_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/lbs_norm.sv
// ----------------------------------------------------------------------------
// lbs_norm
// iterative normal normalization: shift, squares, square root, divides
// ----------------------------------------------------------------------------
module lbs_norm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [2:0][47:0]  nsum,
    output logic              done,
    output logic [2:0][15:0]  nrm
);

    lbs_pkg::norm_state_t state_reg, state_next;

    logic [2:0][47:0] mag_reg;
    logic [2:0]       neg_reg;
    logic [47:0]      m_reg;
    logic [61:0]      sq_reg;
    logic [63:0]      len2_reg;
    logic [1:0]       idx_reg;
    logic [63:0]      x_reg;
    logic [63:0]      res_reg;
    logic [63:0]      bit_reg;
    logic [16:0]      low_reg;
    logic [33:0]      rem_reg;
    logic [16:0]      q_reg;
    logic [4:0]       step_reg;
    logic [1:0]       c_reg;
    logic [2:0][15:0] nrm_reg;

    logic [47:0] m_max;
    logic [63:0] trial;
    logic [47:0] num;
    logic [33:0] shifted;
    logic [14:0] q_cap;

    assign done  = (state_reg == lbs_pkg::N_DONE);
    assign nrm   = nrm_reg;
    assign trial = res_reg + bit_reg;
    assign num   = 48'({mag_reg[c_reg][30:0], 15'd0}) + 48'(res_reg[32:1]);
    assign shifted = {rem_reg[32:0], low_reg[16]};
    assign q_cap = (q_reg > 17'd32767) ? 15'h7fff : q_reg[14:0];

    always_comb begin
        m_max = mag_reg[0];
        if (mag_reg[1] > m_max) begin
            m_max = mag_reg[1];
        end
        if (mag_reg[2] > m_max) begin
            m_max = mag_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbs_pkg::N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lbs_pkg::N_IDLE: begin
                if (start) begin
                    state_next = lbs_pkg::N_MAX;
                end
            end
            lbs_pkg::N_MAX: begin
                state_next = (m_max == 48'd0) ? lbs_pkg::N_DONE : lbs_pkg::N_SHIFT;
            end
            lbs_pkg::N_SHIFT: begin
                if (m_reg >= 48'h4000_0000 && m_reg[47:31] == 17'd0) begin
                    state_next = lbs_pkg::N_SQ;
                end
            end
            lbs_pkg::N_SQ: begin
                if (idx_reg == 2'd3) begin
                    state_next = lbs_pkg::N_SQRT;
                end
            end
            lbs_pkg::N_SQRT: begin
                if (bit_reg == 64'd1) begin
                    state_next = lbs_pkg::N_DIV_INIT;
                end
            end
            lbs_pkg::N_DIV_INIT: state_next = lbs_pkg::N_DIV_STEP;
            lbs_pkg::N_DIV_STEP: begin
                if (step_reg == 5'd16) begin
                    state_next = lbs_pkg::N_DIV_END;
                end
            end
            lbs_pkg::N_DIV_END: begin
                state_next = (c_reg == 2'd2) ? lbs_pkg::N_DONE : lbs_pkg::N_DIV_INIT;
            end
            lbs_pkg::N_DONE: state_next = lbs_pkg::N_IDLE;
            default: state_next = lbs_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            lbs_pkg::N_IDLE: begin
                for (int c = 0; c < 3; c++) begin
                    neg_reg[c] <= nsum[c][47];
                    mag_reg[c] <= nsum[c][47] ? (48'd0 - nsum[c]) : nsum[c];
                end
            end
            lbs_pkg::N_MAX: begin
                m_reg <= m_max;
                if (m_max == 48'd0) begin
                    nrm_reg <= '0;
                end
            end
            lbs_pkg::N_SHIFT: begin
                if (m_reg < 48'h4000_0000) begin
                    m_reg <= m_reg << 1;
                    for (int c = 0; c < 3; c++) begin
                        mag_reg[c] <= mag_reg[c] << 1;
                    end
                end else if (m_reg[47:31] != 17'd0) begin
                    m_reg <= m_reg >> 1;
                    for (int c = 0; c < 3; c++) begin
                        mag_reg[c] <= mag_reg[c] >> 1;
                    end
                end else begin
                    idx_reg  <= 2'd0;
                    len2_reg <= 64'd0;
                end
            end
            lbs_pkg::N_SQ: begin
                if (idx_reg != 2'd3) begin
                    sq_reg <= mag_reg[idx_reg][30:0] * mag_reg[idx_reg][30:0];
                end
                if (idx_reg != 2'd0) begin
                    len2_reg <= len2_reg + 64'(sq_reg);
                end
                if (idx_reg == 2'd3) begin
                    x_reg   <= len2_reg + 64'(sq_reg);
                    res_reg <= 64'd0;
                    bit_reg <= 64'd1 << 62;
                end
                idx_reg <= idx_reg + 2'd1;
            end
            lbs_pkg::N_SQRT: begin
                if (x_reg >= trial) begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                c_reg   <= 2'd0;
            end
            lbs_pkg::N_DIV_INIT: begin
                rem_reg  <= 34'(num >> 17);
                low_reg  <= num[16:0];
                q_reg    <= 17'd0;
                step_reg <= 5'd0;
            end
            lbs_pkg::N_DIV_STEP: begin
                if (shifted >= 34'(res_reg[32:0])) begin
                    rem_reg <= shifted - 34'(res_reg[32:0]);
                    q_reg   <= {q_reg[15:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
                low_reg  <= low_reg << 1;
                step_reg <= step_reg + 5'd1;
            end
            lbs_pkg::N_DIV_END: begin
                nrm_reg[c_reg] <= neg_reg[c_reg] ? (16'd0 - {1'b0, q_cap}) : {1'b0, q_cap};
                c_reg <= c_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/lbs_back.sv
// ----------------------------------------------------------------------------
// lbs_back
// matrix store, per-influence transform and blend, result register
// ----------------------------------------------------------------------------
module lbs_back #(
    parameter int BONE_COUNT     = 256,
    parameter int MAX_INFLUENCES = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  lbs_pkg::item_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [143:0]   m_tdata
);

    localparam int DEPTH = BONE_COUNT * lbs_pkg::MAT_ELEMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_INFLUENCES + 1);

    lbs_pkg::back_state_t state_reg, state_next;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    logic signed [31:0] bind_pos_reg [3];
    logic signed [15:0] bind_nrm_reg [3];
    logic signed [31:0] b_reg [3];
    logic signed [63:0] psum_reg [3];
    logic signed [47:0] nsum_reg [3];
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      base_reg;
    logic [15:0]        w_reg;
    logic               last_reg;
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic signed [63:0] pm_reg;
    logic signed [47:0] nm_reg;
    logic signed [49:0] tacc_reg;
    logic signed [49:0] sacc_reg;
    logic signed [31:0] tfin_reg;
    logic signed [33:0] sfin_reg;
    logic signed [49:0] tw_reg;
    logic signed [51:0] sw_reg;
    logic               m_tvalid_reg;
    logic [143:0]       m_tdata_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      head_base;
    logic [AW-1:0]      rd_addr;
    logic [1:0]         ridx;
    logic signed [49:0] pm_round;
    logic signed [49:0] tsum;
    logic signed [31:0] tsat;
    logic signed [64:0] pnew;
    logic signed [52:0] nnew;
    logic               norm_start;
    logic               norm_done;
    logic [2:0][47:0]   nsum_flat;
    logic [2:0][15:0]   nrm_res;
    logic [2:0][31:0]   pos_out;
    logic               out_free;
    logic               infl_go;
    logic signed [31:0] offs [3];
    logic signed [32:0] bsum [3];

    assign head_base = AW'({q_head.bone, 3'd0}) + AW'({q_head.bone, 2'd0});
    assign wr_addr   = head_base + AW'(q_head.element);
    assign rd_addr   = base_reg + AW'({row_reg, 1'b0}) + AW'(row_reg) + AW'(col_reg);
    assign ridx      = (row_reg == 2'd3) ? 2'd0 : row_reg;
    assign pm_round  = 50'(pm_reg >>> 16) + 50'(pm_reg[15]);
    assign tsum      = tacc_reg + 50'(rd_data_reg);
    assign tsat      = (tsum > 50'sh7fff_ffff) ? 32'sh7fff_ffff :
                       (tsum < -50'sh8000_0000) ? -32'sh8000_0000 : 32'(tsum);
    assign pnew      = 65'(psum_reg[col_reg]) + 65'(tw_reg);
    assign nnew      = 53'(nsum_reg[col_reg]) + 53'(sw_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign infl_go   = q_head.infl_ok && (count_reg < CW'(MAX_INFLUENCES));
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign offs[0] = q_head.pos_x;
    assign offs[1] = q_head.pos_y;
    assign offs[2] = q_head.pos_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nsum_flat[c] = nsum_reg[c];
            bsum[c]      = 33'(bind_pos_reg[c]) + 33'(offs[c]);
        end
    end

    always_comb begin
        logic signed [49:0] pr;
        for (int c = 0; c < 3; c++) begin
            pr = 50'(psum_reg[c] >>> 15) + 50'(psum_reg[c][14]);
            if (pr > 50'sh7fff_ffff) begin
                pos_out[c] = 32'h7fff_ffff;
            end else if (pr < -50'sh8000_0000) begin
                pos_out[c] = 32'h8000_0000;
            end else begin
                pos_out[c] = 32'(pr);
            end
        end
    end

    lbs_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .nsum    (nsum_flat),
        .done    (norm_done),
        .nrm     (nrm_res)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= q_head.matrix_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbs_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        norm_start = 1'b0;
        unique case (state_reg)
            lbs_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        lbs_pkg::MODE_LOAD: wr_en = q_head.load_ok;
                        lbs_pkg::MODE_INFL: begin
                            if (infl_go) begin
                                state_next = lbs_pkg::B_ELEM_WAIT;
                            end else if (q_head.last) begin
                                state_next = lbs_pkg::B_NORM_START;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lbs_pkg::B_ELEM_WAIT: state_next = lbs_pkg::B_ELEM_MUL;
            lbs_pkg::B_ELEM_MUL:  state_next = lbs_pkg::B_ELEM_ACC;
            lbs_pkg::B_ELEM_ACC: begin
                state_next = (row_reg == 2'd3) ? lbs_pkg::B_WGT_MUL : lbs_pkg::B_ELEM_WAIT;
            end
            lbs_pkg::B_WGT_MUL: state_next = lbs_pkg::B_WGT_ADD;
            lbs_pkg::B_WGT_ADD: begin
                state_next = (col_reg == 2'd2) ? lbs_pkg::B_FINISH : lbs_pkg::B_ELEM_WAIT;
            end
            lbs_pkg::B_FINISH: begin
                state_next = last_reg ? lbs_pkg::B_NORM_START : lbs_pkg::B_IDLE;
            end
            lbs_pkg::B_NORM_START: begin
                norm_start = 1'b1;
                state_next = lbs_pkg::B_NORM_WAIT;
            end
            lbs_pkg::B_NORM_WAIT: begin
                if (norm_done) begin
                    state_next = lbs_pkg::B_OUT;
                end
            end
            lbs_pkg::B_OUT: begin
                if (out_free) begin
                    state_next = lbs_pkg::B_IDLE;
                end
            end
            default: state_next = lbs_pkg::B_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            lbs_pkg::B_IDLE: begin
                base_reg <= head_base;
                w_reg    <= q_head.weight;
                last_reg <= q_head.last;
                row_reg  <= 2'd0;
                col_reg  <= 2'd0;
                tacc_reg <= '0;
                sacc_reg <= '0;
                for (int c = 0; c < 3; c++) begin
                    if (bsum[c] > 33'sh7fff_ffff) begin
                        b_reg[c] <= 32'sh7fff_ffff;
                    end else if (bsum[c] < -33'sh8000_0000) begin
                        b_reg[c] <= -32'sh8000_0000;
                    end else begin
                        b_reg[c] <= 32'(bsum[c]);
                    end
                end
            end
            lbs_pkg::B_ELEM_MUL: begin
                pm_reg <= b_reg[ridx] * rd_data_reg;
                nm_reg <= bind_nrm_reg[ridx] * rd_data_reg;
            end
            lbs_pkg::B_ELEM_ACC: begin
                if (row_reg == 2'd3) begin
                    tfin_reg <= tsat;
                    sfin_reg <= 34'(sacc_reg >>> 16) + 34'(sacc_reg[15]);
                end else begin
                    tacc_reg <= tacc_reg + pm_round;
                    sacc_reg <= sacc_reg + 50'(nm_reg);
                    row_reg  <= row_reg + 2'd1;
                end
            end
            lbs_pkg::B_WGT_MUL: begin
                tw_reg <= tfin_reg * $signed({1'b0, w_reg});
                sw_reg <= sfin_reg * $signed({1'b0, w_reg});
            end
            lbs_pkg::B_WGT_ADD: begin
                tacc_reg <= '0;
                sacc_reg <= '0;
                row_reg  <= 2'd0;
                col_reg  <= col_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    // vertex state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                bind_pos_reg[c] <= '0;
                bind_nrm_reg[c] <= '0;
                psum_reg[c]     <= '0;
                nsum_reg[c]     <= '0;
            end
        end else begin
            if (state_reg == lbs_pkg::B_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                lbs_pkg::B_IDLE: begin
                    if (!q_empty && q_head.kind == lbs_pkg::MODE_START) begin
                        bind_pos_reg[0] <= q_head.pos_x;
                        bind_pos_reg[1] <= q_head.pos_y;
                        bind_pos_reg[2] <= q_head.pos_z;
                        bind_nrm_reg[0] <= q_head.nrm_x;
                        bind_nrm_reg[1] <= q_head.nrm_y;
                        bind_nrm_reg[2] <= q_head.nrm_z;
                        count_reg       <= '0;
                        for (int c = 0; c < 3; c++) begin
                            psum_reg[c] <= '0;
                            nsum_reg[c] <= '0;
                        end
                    end
                end
                lbs_pkg::B_WGT_ADD: begin
                    if (pnew > 65'sh7fff_ffff_ffff_ffff) begin
                        psum_reg[col_reg] <= 64'sh7fff_ffff_ffff_ffff;
                    end else if (pnew < -65'sh8000_0000_0000_0000) begin
                        psum_reg[col_reg] <= -64'sh8000_0000_0000_0000;
                    end else begin
                        psum_reg[col_reg] <= 64'(pnew);
                    end
                    if (nnew > 53'sh7fff_ffff_ffff) begin
                        nsum_reg[col_reg] <= 48'sh7fff_ffff_ffff;
                    end else if (nnew < -53'sh8000_0000_0000) begin
                        nsum_reg[col_reg] <= -48'sh8000_0000_0000;
                    end else begin
                        nsum_reg[col_reg] <= 48'(nnew);
                    end
                    if (col_reg == 2'd2) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                lbs_pkg::B_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {nrm_res[2], nrm_res[1], nrm_res[0],
                                         pos_out[2], pos_out[1], pos_out[0]};
                        count_reg    <= '0;
                        for (int c = 0; c < 3; c++) begin
                            psum_reg[c] <= '0;
                            nsum_reg[c] <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/linear_blend_skinning_unit.sv
// latency: load and start requests retire in one back-end cycle after queuing
// an influence takes 44 cycles: 12 matrix reads at 3 cycles each plus weighting
// a final influence adds 98 to 128 cycles for shift, 32-step square root and
// three 17-step divides, or 4 cycles when the blended normal is zero
// throughput: one request at a time in the back end, two more wait in the queue
// reset: synchronous active-low; bind data, sums and control clear, matrix store does not
// ----------------------------------------------------------------------------
// linear_blend_skinning_unit
// vertex skinning engine with up to four weighted bone influences
// ----------------------------------------------------------------------------
module linear_blend_skinning_unit #(
    parameter int BONE_COUNT     = 256,
    parameter int MAX_INFLUENCES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bone, element, matrix_value, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, weight
    input  logic [207:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_nx, out_ny, out_nz
    output logic [143:0] m_tdata
);

    lbs_pkg::item_t push_item;
    lbs_pkg::item_t head;
    logic           push;
    logic           full;
    logic           pop;
    logic           empty;

    lbs_front #(
        .BONE_COUNT (BONE_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    lbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    lbs_back #(
        .BONE_COUNT     (BONE_COUNT),
        .MAX_INFLUENCES (MAX_INFLUENCES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: bench/lbs_checker.sv
// ----------------------------------------------------------------------------
// lbs_checker
// watches both channels of the skinning unit, predicts every skinned vertex
// from the accepted requests and compares it field by field
// ----------------------------------------------------------------------------
module lbs_checker #(
    parameter int BONE_COUNT     = 256,
    parameter int MAX_INFLUENCES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [207:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM48_MIN = -SUM48_MAX - 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } vertex_t;

    logic signed [31:0] skin_mat [BONE_COUNT*lbs_pkg::MAT_ELEMS];
    logic signed [31:0] bind_pos [3];
    logic signed [15:0] bind_nrm [3];
    longint             pos_acc  [3];
    longint             nrm_acc  [3];
    int                 infl_cnt;
    vertex_t            skinned_q[$];

    function automatic longint rnd16(longint v);
        return (v >>> 16) + ((v >>> 15) & 1);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint acc64(longint a, longint b);
        if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && a < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b)
            return -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        return a + b;
    endfunction

    function automatic longint acc48(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM48_MAX) return SUM48_MAX;
        if (s < SUM48_MIN) return SUM48_MIN;
        return s;
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vertex_t blend_vertex();
        vertex_t            v;
        longint unsigned    mag [3];
        longint unsigned    m, len2, len, q;
        logic               neg [3];
        logic signed [15:0] nv  [3];
        v.x = 32'(clip32((pos_acc[0] >>> 15) + ((pos_acc[0] >>> 14) & 1)));
        v.y = 32'(clip32((pos_acc[1] >>> 15) + ((pos_acc[1] >>> 14) & 1)));
        v.z = 32'(clip32((pos_acc[2] >>> 15) + ((pos_acc[2] >>> 14) & 1)));
        m = 0;
        for (int c = 0; c < 3; c++) begin
            neg[c] = nrm_acc[c] < 0;
            mag[c] = neg[c] ? -nrm_acc[c] : nrm_acc[c];
            if (mag[c] > m) m = mag[c];
            nv[c] = '0;
        end
        if (m != 0) begin
            while (m < (64'd1 << 30)) begin
                m <<= 1;
                for (int c = 0; c < 3; c++) mag[c] <<= 1;
            end
            while (m >= (64'd1 << 31)) begin
                m >>= 1;
                for (int c = 0; c < 3; c++) mag[c] >>= 1;
            end
            len2 = 0;
            for (int c = 0; c < 3; c++) len2 += mag[c] * mag[c];
            len = sqrt_floor(len2);
            for (int c = 0; c < 3; c++) begin
                q = len != 0 ? (mag[c] * 32768 + len / 2) / len : 0;
                if (q > 32767) q = 32767;
                nv[c] = 16'(neg[c] ? -q : q);
            end
        end
        v.nx = nv[0];
        v.ny = nv[1];
        v.nz = nv[2];
        return v;
    endfunction

    task automatic skin_request(input logic [1:0] kind, input logic [207:0] d,
                                input logic lst);
        logic [7:0]         bone;
        logic [3:0]         elem;
        logic signed [31:0] p [3];
        logic signed [15:0] n [3];
        longint             w, b [3], t, s, mx;
        bone = d[7:0];
        elem = d[11:8];
        p[0] = d[75:44];
        p[1] = d[107:76];
        p[2] = d[139:108];
        n[0] = d[155:140];
        n[1] = d[171:156];
        n[2] = d[187:172];
        w = 64'(d[203:188]);
        case (kind)
            lbs_pkg::MODE_LOAD: begin
                if (bone < BONE_COUNT && elem < lbs_pkg::MAT_ELEMS)
                    skin_mat[bone*lbs_pkg::MAT_ELEMS+elem] = d[43:12];
            end
            lbs_pkg::MODE_START: begin
                for (int c = 0; c < 3; c++) begin
                    bind_pos[c] = p[c];
                    bind_nrm[c] = n[c];
                    pos_acc[c] = 0;
                    nrm_acc[c] = 0;
                end
                infl_cnt = 0;
            end
            lbs_pkg::MODE_INFL: begin
                if (w > 32768) w = 32768;
                if (w != 0 && bone < BONE_COUNT && infl_cnt < MAX_INFLUENCES) begin
                    infl_cnt++;
                    for (int c = 0; c < 3; c++)
                        b[c] = clip32(longint'(bind_pos[c]) + longint'(p[c]));
                    for (int c = 0; c < 3; c++) begin
                        t = 0;
                        s = 0;
                        for (int r = 0; r < 3; r++) begin
                            mx = longint'(skin_mat[bone*lbs_pkg::MAT_ELEMS+r*3+c]);
                            t += rnd16(b[r] * mx);
                            s += longint'(bind_nrm[r]) * mx;
                        end
                        t = clip32(t + longint'(skin_mat[bone*lbs_pkg::MAT_ELEMS+9+c]));
                        s = rnd16(s);
                        pos_acc[c] = acc64(pos_acc[c], t * w);
                        nrm_acc[c] = acc48(nrm_acc[c], s * w);
                    end
                end
                if (lst) begin
                    skinned_q.insert(skinned_q.size(), blend_vertex());
                    for (int c = 0; c < 3; c++) begin
                        pos_acc[c] = 0;
                        nrm_acc[c] = 0;
                    end
                    infl_cnt = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input longint exp_v,
                                 input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        vertex_t got, want;
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                bind_pos[c] = 0;
                bind_nrm[c] = 0;
                pos_acc[c] = 0;
                nrm_acc[c] = 0;
            end
            infl_cnt = 0;
            fail_count = 0;
            skinned_q.delete();
        end else begin
            if (s_tvalid && s_tready) skin_request(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                       m_tdata[111:96], m_tdata[127:112], m_tdata[143:128]};
                if (skinned_q.size() == 0) begin
                    $error("vertex result with none expected");
                    fail_count++;
                end else begin
                    want = skinned_q.pop_front();
                    compare_field("out_x", want.x, got.x);
                    compare_field("out_y", want.y, got.y);
                    compare_field("out_z", want.z, got.z);
                    compare_field("out_nx", want.nx, got.nx);
                    compare_field("out_ny", want.ny, got.ny);
                    compare_field("out_nz", want.nz, got.nz);
                end
            end
        end
        pending = skinned_q.size();
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the skinning unit: matrix loads for a set of bones, then
// directed corner vertices and random vertices, with bursty requests and a
// stalling result side
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BONES = 256;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    int           fail_count;
    int           pending;
    logic         hold_off;
    logic         loaded [NUM_BONES];
    int           burst_left;

    linear_blend_skinning_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lbs_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode_sel;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) m_tready <= 1'b0;
            else begin
                mode_sel = ($urandom_range(0, 999) / 250);
                case (mode_sel)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [7:0] bone,
                                input logic [3:0] elem, input logic [31:0] mv,
                                input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] pz, input logic [15:0] nx,
                                input logic [15:0] ny, input logic [15:0] nz,
                                input logic [15:0] w, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= lst;
        s_tdata  <= {4'h0, w, nz, ny, nx, pz, py, px, mv, elem, bone};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic load_bone(input int bone);
        for (int e = 0; e < lbs_pkg::MAT_ELEMS; e++)
            send_request(lbs_pkg::MODE_LOAD, bone, e, rand_elem(), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 1));
        loaded[bone] = 1'b1;
    endtask

    function automatic logic [7:0] pick_bone();
        int b;
        do b = $urandom_range(0, NUM_BONES - 1); while (!loaded[b]);
        return 8'(b);
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return $urandom_range(32769, 65535);
            default: return $urandom_range(1, 32768);
        endcase
    endfunction

    task automatic send_vertex(input int n_infl);
        send_request(lbs_pkg::MODE_START, $urandom, $urandom, $urandom, rand_coord(),
                     rand_coord(), rand_coord(), $urandom, $urandom, $urandom,
                     $urandom, $urandom_range(0, 1));
        for (int i = 0; i < n_infl; i++)
            send_request(lbs_pkg::MODE_INFL, pick_bone(), $urandom, $urandom,
                         rand_coord(), rand_coord(), rand_coord(), $urandom,
                         $urandom, $urandom, rand_weight(), i == n_infl - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        hold_off = 1'b0;
        burst_left = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= lbs_pkg::MODE_LOAD;
        s_tlast  <= 1'b0;
        for (int b = 0; b < NUM_BONES; b++) loaded[b] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_bone(0);
        load_bone(255);
        for (int i = 0; i < 6; i++) load_bone($urandom_range(1, 254));

        // ignored requests: bad element, unused mode
        send_request(lbs_pkg::MODE_LOAD, 8'd0, 4'd12, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0,
                     0, 0);
        send_request(lbs_pkg::MODE_LOAD, 8'd0, 4'd15, 32'h8000_0000, 0, 0, 0, 0, 0, 0,
                     0, 1);
        send_request(lbs_pkg::MODE_NONE, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
        // extremes of position and normal, full weight
        send_request(lbs_pkg::MODE_START, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 1);
        send_request(lbs_pkg::MODE_INFL, 8'd0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                     0, 0, 0, 16'd32768, 0);
        send_request(lbs_pkg::MODE_INFL, 8'd255, 0, 0, 0, 0, 32'h8000_0000,
                     0, 0, 0, 16'hFFFF, 1);
        // zero weight only, skipped last still emits, zero normal
        send_request(lbs_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(lbs_pkg::MODE_INFL, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0, 1);
        send_request(lbs_pkg::MODE_INFL, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd1000, 1);
        // too many influences, then reuse of bind data without a new start
        send_request(lbs_pkg::MODE_START, 0, 0, 0, 32'h0001_0000, 0, 0, 16'h4000, 0, 0,
                     0, 0);
        for (int i = 0; i < 6; i++)
            send_request(lbs_pkg::MODE_INFL, 8'd255, 0, 0, 0, 0, 0, 0, 0, 0, 16'd32768,
                         i == 5);
        send_request(lbs_pkg::MODE_INFL, 8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd16384, 1);
        wait_drained();

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int v = 0; v < 15; v++) send_vertex(1);
        join
        wait_drained();

        for (int it = 0; it < 1750; ) begin
            case ($urandom_range(0, 19))
                0: begin
                    load_bone($urandom_range(0, NUM_BONES - 1));
                    it += lbs_pkg::MAT_ELEMS;
                end
                1: begin
                    send_request($urandom_range(0, 1) ? lbs_pkg::MODE_NONE
                                                      : lbs_pkg::MODE_LOAD,
                                 $urandom, $urandom_range(12, 15), $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom_range(0, 1));
                    it++;
                end
                2: begin
                    send_request(lbs_pkg::MODE_INFL, pick_bone(), $urandom, $urandom,
                                 rand_coord(), rand_coord(), rand_coord(), $urandom,
                                 $urandom, $urandom, rand_weight(), 1);
                    it++;
                end
                default: begin
                    int n;
                    n = $urandom_range(1, 6);
                    send_vertex(n);
                    it += n + 1;
                end
            endcase
            if (it % 400 < 5) wait_drained();
        end
        wait_drained();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
